### rtl/kpid_pkg.sv
// ============================================================================
// kpid_pkg
// Types and constants shared by the packet input decoder.
// ============================================================================
package kpid_pkg;

    localparam int KEY_CODES = 128;
    localparam int KEY_AW    = $clog2(KEY_CODES);
    localparam int MAX_EVENTS = 4;
    localparam int EV_CW      = $clog2(MAX_EVENTS + 1);
    localparam int EV_IW      = $clog2(MAX_EVENTS);

    localparam int IN_W  = 120;
    localparam int OUT_W = 56;

    localparam logic [31:0] MAGIC_OK = 32'h414B_564D;
    localparam logic [7:0]  VERSION_OK = 8'd1;

    localparam logic [7:0] KIND_KEY    = 8'd1;
    localparam logic [7:0] KIND_MOVE   = 8'd2;
    localparam logic [7:0] KIND_BUTTON = 8'd3;
    localparam logic [7:0] KIND_MOUSE  = 8'd7;

    localparam logic [10:0] LEN_HDR    = 11'd8;
    localparam logic [10:0] LEN_KEY    = 11'd10;
    localparam logic [10:0] LEN_MOVE   = 11'd12;
    localparam logic [10:0] LEN_MOUSE  = 11'd13;

    localparam logic [7:0]  CODE_NONE     = 8'hFF;
    localparam logic [6:0]  BTN_CODE_BASE = 7'h68;
    localparam logic [3:0]  MOD_KEY_ROW   = 4'hC;   // key codes 0x60..0x67
    localparam logic [7:0]  MOD_MASK      = 8'hFB;  // 0x62 carries no qualifier
    localparam logic [15:0] Q_RELMOUSE    = 16'h8000;

    localparam logic [0:0] CLASS_KEY   = 1'b0;
    localparam logic [0:0] CLASS_MOUSE = 1'b1;

    typedef struct packed {
        logic [4:0]  pad;
        logic [7:0]  p4;
        logic [7:0]  p3;
        logic [7:0]  p2;
        logic [7:0]  p1;
        logic [7:0]  p0;
        logic [15:0] seq;
        logic [7:0]  kind;
        logic [7:0]  ver;
        logic [31:0] magic;
        logic [10:0] len;
    } pkt_t;

    typedef struct packed {
        logic               cls;
        logic signed [15:0] my;
        logic signed [15:0] mx;
        logic [15:0]        qual;
        logic [7:0]         code;
    } event_t;

endpackage

### rtl/kvm_packet_input_decoder.sv
// ============================================================================
// kvm_packet_input_decoder
// Decodes received link packets into raw key and mouse events.
//
// s_t*: one item per packet; tdata from bit 0 up: packet_length(11),
// magic_word(32), version_byte(8), packet_kind(8), sequence_number(16),
// payload_byte0..payload_byte4(8 each), zero fill to 120 bits.
// m_t*: one item per event; tdata from bit 0 up: event_code(8),
// qualifier_bits(16), move_x(16), move_y(16); tuser = event_class;
// tlast = last_event of the packet.
// A packet is registered at acceptance while its key-table entry is read from
// a 128x1 synchronous RAM; the decode stage then decodes it, writes the entry
// back and loads up to four events into an event buffer. The first event is
// valid the cycle after decode. Packets are accepted back to back, the decode
// stage waiting while the event buffer holds more than one event, or holds its
// last event and m_tready is low.
// A write-back register forwards the latest table write to the next read.
// Reset clears the held-key valid bits, buttons and sequence state at once;
// no clearing pass. When m_tready is low the buffered event holds and the
// input stalls once the decode stage is full.
// ============================================================================
module kvm_packet_input_decoder
    import kpid_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // len, magic, ver, kind, seq, p0..p4
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,   // code, qual, move_x, move_y
    output logic             m_tuser,   // event_class
    output logic             m_tlast
);

    pkt_t               in_pkt;
    logic [KEY_AW-1:0]  in_addr;

    logic               s1_valid_reg;
    pkt_t               s1_pkt_reg;
    logic               rd_data_reg;
    logic               rd_vld_reg;

    logic               key_mem [KEY_CODES];
    logic [KEY_CODES-1:0] key_vld_reg;

    logic               fwd_vld_reg;
    logic [KEY_AW-1:0]  fwd_addr_reg;
    logic               fwd_data_reg;

    logic [7:0]         mods_reg;
    logic [7:0]         mods_next;
    logic [2:0]         buttons_reg;
    logic [2:0]         buttons_next;
    logic               btn_upd;
    logic [15:0]        prev_seq_reg;
    logic               seq_seen_reg;

    event_t             ev_reg [MAX_EVENTS];
    logic [EV_IW-1:0]   ev_idx_reg;
    logic [EV_CW-1:0]   ev_left_reg;

    logic               buf_free;
    logic               s1_go;
    logic               hdr_ok;
    logic [KEY_AW-1:0]  s1_addr;
    logic               key_old;
    logic               mem_we;
    logic               key_new;
    event_t             evs [MAX_EVENTS];
    logic [EV_CW-1:0]   ev_cnt;
    event_t             head;

    assign in_pkt  = pkt_t'(s_tdata);
    assign in_addr = in_pkt.p0[KEY_AW-1:0];
    assign s1_addr = s1_pkt_reg.p0[KEY_AW-1:0];

    assign buf_free = (ev_left_reg == '0) ||
                      (ev_left_reg == EV_CW'(1) && m_tready);
    assign s1_go    = s1_valid_reg && buf_free;
    assign s_tready = !s1_valid_reg || buf_free;

    assign head     = ev_reg[ev_idx_reg];
    assign m_tvalid = (ev_left_reg != '0);
    assign m_tdata  = {head.my, head.mx, head.qual, head.code};
    assign m_tuser  = head.cls;
    assign m_tlast  = (ev_left_reg == EV_CW'(1));

    always_comb begin
        logic [2:0]  nb;
        logic [2:0]  ch;
        logic [2:0]  bmask;
        logic        do_move;
        logic        do_key_ev;
        logic [15:0] kq;
        logic [15:0] mq;
        logic [15:0] dx;
        logic [15:0] dy;
        event_t      blank;

        hdr_ok = (s1_pkt_reg.len >= LEN_HDR) && (s1_pkt_reg.magic == MAGIC_OK) &&
                 (s1_pkt_reg.ver == VERSION_OK) &&
                 !(seq_seen_reg && s1_pkt_reg.seq == prev_seq_reg);

        key_old = (fwd_vld_reg && fwd_addr_reg == s1_addr) ? fwd_data_reg
                                                            : (rd_vld_reg & rd_data_reg);
        key_new = (s1_pkt_reg.p1 != 8'd0);

        do_key_ev = hdr_ok && s1_pkt_reg.kind == KIND_KEY &&
                    s1_pkt_reg.len >= LEN_KEY && !s1_pkt_reg.p0[7] &&
                    (key_new || key_old);
        mem_we = s1_go && do_key_ev;

        mods_next = mods_reg;
        if (do_key_ev && s1_pkt_reg.p0[6:3] == MOD_KEY_ROW) begin
            mods_next[s1_pkt_reg.p0[2:0]] = key_new;
        end

        dx = {s1_pkt_reg.p0, s1_pkt_reg.p1};
        dy = {s1_pkt_reg.p2, s1_pkt_reg.p3};
        nb = buttons_reg;
        btn_upd = 1'b0;
        do_move = 1'b0;
        bmask = 3'b000;
        case (s1_pkt_reg.kind)
            KIND_MOVE: begin
                do_move = hdr_ok && s1_pkt_reg.len >= LEN_MOVE &&
                          (dx != 16'd0 || dy != 16'd0);
            end
            KIND_BUTTON: begin
                if (hdr_ok && s1_pkt_reg.len >= LEN_KEY && s1_pkt_reg.p0 >= 8'd1 &&
                    s1_pkt_reg.p0 <= 8'd3) begin
                    btn_upd = 1'b1;
                    bmask = 3'b001 << (s1_pkt_reg.p0[1:0] - 2'd1);
                    nb = key_new ? (buttons_reg | bmask) : (buttons_reg & ~bmask);
                end
            end
            KIND_MOUSE: begin
                if (hdr_ok && s1_pkt_reg.len >= LEN_MOUSE) begin
                    btn_upd = 1'b1;
                    nb = s1_pkt_reg.p4[2:0];
                    do_move = (dx != 16'd0 || dy != 16'd0);
                end
            end
            default: begin
            end
        endcase
        buttons_next = nb;
        ch = btn_upd ? (buttons_reg ^ nb) : 3'b000;

        kq = {8'h00, mods_next & MOD_MASK};
        mq = {8'h00, mods_reg & MOD_MASK} | Q_RELMOUSE | {1'b0, nb[0], nb[1], nb[2], 12'h000};

        blank = '0;
        for (int i = 0; i < MAX_EVENTS; i++) begin
            evs[i] = blank;
        end
        ev_cnt = '0;
        if (do_key_ev) begin
            evs[0].cls  = CLASS_KEY;
            evs[0].code = {!key_new, s1_pkt_reg.p0[6:0]};
            evs[0].qual = kq;
            ev_cnt = EV_CW'(1);
        end
        for (int i = 0; i < 3; i++) begin
            if (ch[i]) begin
                evs[ev_cnt[EV_IW-1:0]].cls  = CLASS_MOUSE;
                evs[ev_cnt[EV_IW-1:0]].code = {!nb[i], BTN_CODE_BASE + 7'(i)};
                evs[ev_cnt[EV_IW-1:0]].qual = mq;
                ev_cnt = ev_cnt + EV_CW'(1);
            end
        end
        if (do_move) begin
            evs[ev_cnt[EV_IW-1:0]].cls  = CLASS_MOUSE;
            evs[ev_cnt[EV_IW-1:0]].code = CODE_NONE;
            evs[ev_cnt[EV_IW-1:0]].qual = mq;
            evs[ev_cnt[EV_IW-1:0]].mx   = dx;
            evs[ev_cnt[EV_IW-1:0]].my   = dy;
            ev_cnt = ev_cnt + EV_CW'(1);
        end
    end

    // key table RAM, registered read at acceptance
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            key_mem[s1_addr] <= key_new;
        end
        if (s_tvalid && s_tready) begin
            rd_data_reg <= key_mem[in_addr];
            rd_vld_reg  <= key_vld_reg[in_addr];
            s1_pkt_reg  <= in_pkt;
        end
        if (mem_we) begin
            fwd_addr_reg <= s1_addr;
            fwd_data_reg <= key_new;
        end
        if (s1_go) begin
            for (int i = 0; i < MAX_EVENTS; i++) begin
                ev_reg[i] <= evs[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            key_vld_reg  <= '0;
            fwd_vld_reg  <= 1'b0;
            mods_reg     <= '0;
            buttons_reg  <= '0;
            prev_seq_reg <= '0;
            seq_seen_reg <= 1'b0;
            ev_idx_reg   <= '0;
            ev_left_reg  <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_go) begin
                s1_valid_reg <= 1'b0;
            end
            if (mem_we) begin
                key_vld_reg[s1_addr] <= 1'b1;
                fwd_vld_reg          <= 1'b1;
                mods_reg             <= mods_next;
            end
            if (s1_go && hdr_ok) begin
                seq_seen_reg <= 1'b1;
                prev_seq_reg <= s1_pkt_reg.seq;
            end
            if (s1_go && btn_upd) begin
                buttons_reg <= buttons_next;
            end
            if (s1_go) begin
                ev_idx_reg  <= '0;
                ev_left_reg <= ev_cnt;
            end else if (m_tvalid && m_tready) begin
                ev_idx_reg  <= ev_idx_reg + EV_IW'(1);
                ev_left_reg <= ev_left_reg - EV_CW'(1);
            end
        end
    end

    a_ev_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ev_left_reg <= EV_CW'(MAX_EVENTS))
        else $error("event buffer count out of range");

    a_ev_shown: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_go && ev_cnt != '0 |=> m_tvalid)
        else $error("decoded events not presented");

    a_fwd: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |=> fwd_vld_reg && fwd_data_reg == $past(key_new) &&
                   fwd_addr_reg == $past(s1_addr))
        else $error("forward register missed a table write");

    a_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_go && hdr_ok |=> seq_seen_reg && prev_seq_reg == $past(s1_pkt_reg.seq))
        else $error("sequence state not updated");

    a_idle_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s1_valid_reg |-> s_tready)
        else $error("input stalled with empty decode stage");

endmodule
